FILE: sv/pva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    // atom store geometry (MAX_ATOMS up to 1024, set by the 10-bit atom fields)
    localparam int MAX_ATOMS = 1024;
    localparam int ATOM_W    = 10;
    localparam int ADDR_W    = $clog2(MAX_ATOMS);

    // accumulator and datapath widths
    localparam int ACC_W     = 48;
    localparam int NCOMP     = 6;
    localparam int ROW_W     = NCOMP * ACC_W;
    localparam int IN_W      = 32;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = IN_W + FRAC_W;
    localparam int PMAG_W    = 2 * IN_W - FRAC_W;
    localparam int CHUNK_W   = 16;
    localparam int NCHUNK    = PMAG_W / CHUNK_W;
    localparam int PROD_W    = QUO_W + PMAG_W;
    localparam int MAG_W     = PROD_W - FRAC_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (ACC_W - 1);
    localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

    // configuration register indexes
    localparam logic CFG_GLOBAL_EN = 1'b0;
    localparam logic CFG_ATOM_EN   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic [NCOMP-1:0][ACC_W-1:0] acc_row_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PMUL,
        S_VMUL,
        S_TERM,
        S_ROWA_RD,
        S_ROWA_WR,
        S_ROWB_RD,
        S_ROWB_WR,
        S_RD_RD,
        S_RD_CAP,
        S_FINISH
    } pva_state_t;

    // first and second axis of each tensor component: xx yy zz yz xz xy
    function automatic logic [1:0] comp_a(input logic [2:0] k);
        logic [1:0] a;
        case (k)
            3'd1, 3'd3: a = 2'd1;
            3'd2:       a = 2'd2;
            default:    a = 2'd0;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] comp_b(input logic [2:0] k);
        logic [1:0] b;
        case (k)
            3'd1, 3'd5:       b = 2'd1;
            3'd2, 3'd3, 3'd4: b = 2'd2;
            default:          b = 2'd0;
        endcase
        return b;
    endfunction

    function automatic logic [IN_W-1:0] mag32(input logic [IN_W-1:0] x);
        return x[IN_W-1] ? (~x + IN_W'(1)) : x;
    endfunction

    // saturating signed add, msb of result flags saturation
    function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] t);
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] v;
        logic             ovf;
        sum = {a[ACC_W-1], a} + {t[ACC_W-1], t};
        ovf = sum[ACC_W] ^ sum[ACC_W-1];
        if (ovf)
        begin
            v = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            v = sum[ACC_W-1:0];
        end
        return {ovf, v};
    endfunction

    // clamp a product magnitude to the accumulator range and apply sign
    function automatic logic [ACC_W:0] clamp_term(input logic [MAG_W-1:0] mag,
                                                  input logic neg);
        logic [MAG_W-1:0] lim;
        logic [ACC_W-1:0] m;
        logic             sat;
        lim = neg ? LIM_NEG : LIM_POS;
        sat = mag > lim;
        m   = sat ? lim[ACC_W-1:0] : mag[ACC_W-1:0];
        return {sat, neg ? (~m + ACC_W'(1)) : m};
    endfunction

endpackage

`default_nettype wire

FILE: sv/pair_virial_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                payload
// in        input      in_valid / in_ready      kind, energy_slope, distance, sep_*, atoms
// out       output     out_valid / out_ready    comp_xx .. comp_xy, status
// cfg       input      cfg_we (no wait)         cfg_index, cfg_data
//
// an accumulate transaction holds the block through the divide step (48 quotient bits,
// then done), the steps for each tensor component (product, three 48x16 partial
// products, clamp and global add), the two row read-modify-writes, the load of the
// result register and the return to idle; out_valid rises with the load of the result
// a read transaction reads and captures the row first, a zero distance pair goes straight to the load
// after reset a clearing pass zeroes all MAX_ATOMS rows of the atom store,
// in_ready stays low meanwhile; config writes are taken at any time
// the result register lets the next transaction enter while out_ready is low

module pair_virial_accumulator_core
    import pva_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     kind,
    input  wire logic signed [IN_W-1:0]   energy_slope,
    input  wire logic        [IN_W-1:0]   distance,
    input  wire logic signed [IN_W-1:0]   sep_x,
    input  wire logic signed [IN_W-1:0]   sep_y,
    input  wire logic signed [IN_W-1:0]   sep_z,
    input  wire logic        [ATOM_W-1:0] first_atom,
    input  wire logic        [ATOM_W-1:0] second_atom,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [ACC_W-1:0]       comp_xx,
    output logic signed [ACC_W-1:0]       comp_yy,
    output logic signed [ACC_W-1:0]       comp_zz,
    output logic signed [ACC_W-1:0]       comp_yz,
    output logic signed [ACC_W-1:0]       comp_xz,
    output logic signed [ACC_W-1:0]       comp_xy,
    output logic        [1:0]             status,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic                     cfg_data
);

    pva_state_t state_reg, state_next;

    // control registers
    logic              gen_reg;
    logic              aen_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [2:0]        k_reg;
    logic [1:0]        chunk_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    acc_row_t          glob_reg;

    // transaction payload registers
    logic                   kind_reg;
    logic                   zero_reg;
    logic                   vneg_reg;
    logic [2:0][IN_W-1:0]   sep_reg;
    logic [ATOM_W-1:0]      ia_reg;
    logic [ATOM_W-1:0]      ib_reg;
    logic [QUO_W-1:0]       vmag_reg;
    logic [PMAG_W-1:0]      pmag_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;
    acc_row_t               hterm_reg;
    acc_row_t               rdrow_reg;
    acc_row_t               out_row_reg;
    logic [1:0]             status_reg;

    // divider
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quot;

    // atom store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    // datapath
    logic                ia_ok, ib_ok;
    logic [IN_W-1:0]     da, db;
    logic [2*IN_W-1:0]   pprod;
    logic [QUO_W+CHUNK_W-1:0] part;
    logic [ACC_W:0]      gterm, hterm, gsum;
    acc_row_t            row_old, row_new;
    logic [NCOMP-1:0]    row_sat;
    logic                out_fire;

    assign ia_ok = ({1'b0, ia_reg} < (ATOM_W + 1)'(MAX_ATOMS));
    assign ib_ok = ({1'b0, ib_reg} < (ATOM_W + 1)'(MAX_ATOMS));

    pva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({mag32(energy_slope), FRAC_W'(0)}),
        .denom (distance),
        .done  (div_done),
        .quot  (div_quot)
    );

    pva_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ATOMS)
    ) u_atom_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // per-component product path
    always_comb
    begin
        da    = sep_reg[comp_a(k_reg)];
        db    = sep_reg[comp_b(k_reg)];
        pprod = mag32(da) * mag32(db);
        part  = vmag_reg * pmag_reg[{chunk_reg, 4'b0} +: CHUNK_W];
        gterm = clamp_term(prod_reg[PROD_W-1:FRAC_W], neg_reg);
        hterm = clamp_term({1'b0, prod_reg[PROD_W-1:FRAC_W+1]}, neg_reg);
        gsum  = sat_add(glob_reg[k_reg], gterm[ACC_W-1:0]);
    end

    // row update: six lanes of saturating adds with the half shares
    always_comb
    begin
        row_old = ram_rdata;
        for (int i = 0; i < NCOMP; i++)
        begin
            {row_sat[i], row_new[i]} = sat_add(row_old[i], hterm_reg[i]);
        end
    end

    assign out_fire = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(MAX_ATOMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind)
                    begin
                        state_next = S_RD_RD;
                    end
                    else if (distance == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL:    state_next = S_VMUL;
            S_VMUL:
            begin
                if (chunk_reg == 2'(NCHUNK - 1))
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:    state_next = (k_reg == 3'(NCOMP - 1)) ? S_ROWA_RD : S_PMUL;
            S_ROWA_RD: state_next = S_ROWA_WR;
            S_ROWA_WR: state_next = S_ROWB_RD;
            S_ROWB_RD: state_next = S_ROWB_WR;
            S_ROWB_WR: state_next = S_FINISH;
            S_RD_RD:   state_next = S_RD_CAP;
            S_RD_CAP:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ia_reg[ADDR_W-1:0];
        ram_wdata = row_new;
        ram_raddr = ia_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_valid && !kind && (distance != '0);
            end
            S_ROWA_WR:
            begin
                ram_we = aen_reg && ia_ok;
            end
            S_ROWB_RD:
            begin
                ram_raddr = ib_reg[ADDR_W-1:0];
            end
            S_ROWB_WR:
            begin
                ram_we    = aen_reg && ib_ok;
                ram_waddr = ib_reg[ADDR_W-1:0];
                ram_raddr = ib_reg[ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            gen_reg       <= 1'b1;
            aen_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            chunk_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            glob_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GLOBAL_EN: gen_reg <= cfg_data;
                    CFG_ATOM_EN:   aen_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == S_IDLE)
            begin
                k_reg   <= '0;
                sat_reg <= 1'b0;
            end
            if (state_reg == S_PMUL)
            begin
                chunk_reg <= '0;
            end
            if (state_reg == S_VMUL)
            begin
                chunk_reg <= chunk_reg + 2'(1);
            end
            if (state_reg == S_TERM)
            begin
                k_reg <= k_reg + 3'(1);
                if (gen_reg)
                begin
                    glob_reg[k_reg] <= gsum[ACC_W-1:0];
                end
                if ((gen_reg && (gterm[ACC_W] || gsum[ACC_W])) || (aen_reg && hterm[ACC_W]))
                begin
                    sat_reg <= 1'b1;
                end
            end
            if ((state_reg == S_ROWA_WR && aen_reg && ia_ok && (row_sat != '0)) ||
                (state_reg == S_ROWB_WR && aen_reg && ib_ok && (row_sat != '0)))
            begin
                sat_reg <= 1'b1;
            end
            if (state_reg == S_FINISH && out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg <= kind;
            zero_reg <= (distance == '0);
            vneg_reg <= (energy_slope > 0);
            sep_reg  <= {sep_z, sep_y, sep_x};
            ia_reg   <= first_atom;
            ib_reg   <= second_atom;
        end
        if (div_done)
        begin
            vmag_reg <= div_quot;
        end
        if (state_reg == S_PMUL)
        begin
            pmag_reg <= pprod[2*IN_W-1:FRAC_W];
            neg_reg  <= vneg_reg ^ da[IN_W-1] ^ db[IN_W-1];
            prod_reg <= '0;
        end
        if (state_reg == S_VMUL)
        begin
            prod_reg <= prod_reg + (PROD_W'(part) << {chunk_reg, 4'b0});
        end
        if (state_reg == S_TERM)
        begin
            hterm_reg[k_reg] <= hterm[ACC_W-1:0];
        end
        if (state_reg == S_RD_CAP)
        begin
            rdrow_reg <= ia_ok ? acc_row_t'(ram_rdata) : acc_row_t'('0);
        end
        if (state_reg == S_FINISH && out_fire)
        begin
            out_row_reg <= kind_reg ? rdrow_reg : glob_reg;
            if (kind_reg)
            begin
                status_reg <= ST_OK;
            end
            else if (zero_reg)
            begin
                status_reg <= ST_ZERO;
            end
            else
            begin
                status_reg <= sat_reg ? ST_SAT : ST_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign comp_xx   = out_row_reg[0];
    assign comp_yy   = out_row_reg[1];
    assign comp_zz   = out_row_reg[2];
    assign comp_yz   = out_row_reg[3];
    assign comp_xz   = out_row_reg[4];
    assign comp_xy   = out_row_reg[5];
    assign status    = status_reg;

    // an accepted transaction always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    // the atom store is only written by the clearing pass or an enabled row update
    a_ram_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != S_CLEAR) |-> aen_reg)
        else $error("atom row written while per-atom accumulation disabled");

    // divider completes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    // a result with an undefined status code never appears
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("undefined status code");

endmodule

`default_nettype wire

FILE: sv/pva_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/pva_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_div
    import pva_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [QUO_W-1:0] numer,
    input  wire logic [IN_W-1:0]  denom,
    output logic                  done,
    output logic      [QUO_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [IN_W-1:0]      rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [IN_W-1:0]      den_reg, den_next;
    logic [IN_W:0]        shifted;
    logic [IN_W:0]        diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QUO_W-1]};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (!diff[IN_W])
            begin
                rem_next = diff[IN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[IN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire
